>>> src/block_reference_checker_top_macros.svh
// ----------------------------------------------------------------------------
// block_reference_checker_top_macros.svh
// Assertion macros for the block reference checker; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BLOCK_REFERENCE_CHECKER_TOP_MACROS_SVH
`define BLOCK_REFERENCE_CHECKER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BRC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRC_ASSERT_IMPL(label, ante, cons, msg)
`define BRC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/brc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants of the block reference checker.
// ----------------------------------------------------------------------------
package brc_pkg;

	localparam int MAP_BITS_DEF = 32768;
	localparam int QUEUE_DEPTH  = 4;
	localparam int ROW_BITS     = 32;
	localparam int ROW_SEL_W    = $clog2(ROW_BITS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT = 1'd1;

	localparam logic [3:0] ITYPE_DIR    = 4'd1;
	localparam logic [3:0] ITYPE_FILE   = 4'd2;
	localparam logic [3:0] ITYPE_DEVICE = 4'd3;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_INODE = 2'd1,
		ACT_REF   = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_BIG    = 3'd1,
		ST_ZERO_LINKS = 3'd2,
		ST_RANGE      = 3'd3,
		ST_DOUBLE     = 3'd4,
		ST_FREE       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_RUN,
		BK_CHECK
	} bk_state_t;

	// classified request as it sits in the queue (offset travels beside it)
	typedef struct packed {
		logic [1:0] act;
		logic       in_use;
		logic       links_bad;
		logic       nonzero;
		logic       in_range;
		logic       used;
		logic       too_big;
	} cls_t;

	typedef struct packed {
		logic init;
		logic clearing;
	} bk_status_t;

endpackage

>>> src/brc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/brc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_queue
// Small register FIFO between the classifying front and the map back end.
// ----------------------------------------------------------------------------
module brc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             valid,
	output logic             full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rdata = mem_q[rd_ptr_q];
	assign valid = (count_q != '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/brc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_front
// Holds the region registers and classifies each accepted request.
// ----------------------------------------------------------------------------
module brc_front
	import brc_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        accept,
	input  logic [1:0]                  action,
	input  logic [3:0]                  inode_type,
	input  logic signed [15:0]          link_count,
	input  logic [31:0]                 block_number,
	input  logic                        marked_used,
	output cls_t                        cls,
	output logic [$clog2(MAP_BITS)-1:0] offset,
	output logic                        push
);

	localparam int MAP_IDX_W = $clog2(MAP_BITS);

	logic [31:0] data_start_q;
	logic [15:0] data_count_q;
	logic [32:0] region_end;
	logic [31:0] off_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			data_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DATA_START: data_start_q <= cfg_data;
				REG_DATA_COUNT: data_count_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// region end is one bit wider so it never wraps
	assign region_end = {1'b0, data_start_q} + {17'd0, data_count_q};
	assign off_full   = block_number - data_start_q;

	always_comb begin
		cls.act       = action;
		cls.in_use    = (inode_type == ITYPE_DIR) || (inode_type == ITYPE_FILE) ||
		                (inode_type == ITYPE_DEVICE);
		cls.links_bad = (link_count == 16'sd0) || link_count[15];
		cls.nonzero   = (block_number != 32'd0);
		cls.in_range  = (block_number >= data_start_q) &&
		                ({1'b0, block_number} < region_end) &&
		                (off_full < 32'(MAP_BITS));
		cls.used      = marked_used;
		cls.too_big   = ({16'd0, data_count_q} > 32'(MAP_BITS));
	end

	assign offset = off_full[MAP_IDX_W-1:0];
	assign push   = accept;

endmodule

>>> src/brc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_back
// Executes queued requests against the seen map and the sticky status.
// ----------------------------------------------------------------------------
module brc_back
	import brc_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  cls_t                        head,
	input  logic [$clog2(MAP_BITS)-1:0] head_offset,
	output logic                        pop,
	output bk_status_t                  bk_status,
	output logic                        done,
	output logic [2:0]                  status,
	output logic                        reference_recorded
);

	localparam int ROWS      = (MAP_BITS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_IDX_W = $clog2(ROWS);
	localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(ROWS - 1);

	bk_state_t state_q, state_d;
	logic [ROW_IDX_W-1:0] clr_idx_q;
	logic                 init_q;
	status_t              violation_q, viol_d;
	logic                 active_q, active_d;
	logic                 done_q, rec_q;
	logic [2:0]           status_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic [ROW_SEL_W-1:0] bit_q;
	logic                 used_q;

	logic                 need_check, emit, rec_d;
	logic                 ram_we;
	logic [ROW_IDX_W-1:0] ram_waddr, ram_raddr;
	logic [ROW_BITS-1:0]  ram_wdata, ram_rdata;
	logic                 bit_set;

	assign need_check = (head.act == ACT_REF) && (violation_q == ST_OK) && active_q &&
	                    head.nonzero && head.in_range;
	assign ram_raddr  = head_offset[ROW_SEL_W +: ROW_IDX_W];
	assign bit_set    = ram_rdata[bit_q];

	brc_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_seen_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_idx_q == LAST_ROW) state_d = BK_RUN;
			end
			BK_RUN: begin
				if (q_valid && head.act == ACT_START) begin
					state_d = BK_CLEAR;
				end else if (q_valid && need_check) begin
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: state_d = BK_RUN;
			default:  state_d = BK_RUN;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		rec_d     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		viol_d    = violation_q;
		active_d  = active_q;
		unique case (state_q)
			BK_CLEAR: ram_we = 1'b1;
			BK_RUN: begin
				if (q_valid) begin
					pop  = 1'b1;
					emit = !need_check;
					case (act_t'(head.act))
						ACT_START: begin
							viol_d   = head.too_big ? ST_TOO_BIG : ST_OK;
							active_d = 1'b0;
						end
						ACT_INODE: begin
							if (violation_q == ST_OK) begin
								active_d = head.in_use;
								if (head.in_use && head.links_bad) viol_d = ST_ZERO_LINKS;
							end
						end
						ACT_REF: begin
							if (violation_q == ST_OK && active_q && head.nonzero &&
							    !head.in_range) begin
								viol_d = ST_RANGE;
							end
						end
						default: ;
					endcase
				end
			end
			BK_CHECK: begin
				emit = 1'b1;
				if (bit_set) begin
					viol_d = ST_DOUBLE;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = row_q;
					ram_wdata = ram_rdata | (ROW_BITS'(1) << bit_q);
					rec_d     = 1'b1;
					if (!used_q) viol_d = ST_FREE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && need_check) begin
			row_q  <= head_offset[ROW_SEL_W +: ROW_IDX_W];
			bit_q  <= head_offset[ROW_SEL_W-1:0];
			used_q <= head.used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_idx_q   <= '0;
			init_q      <= 1'b1;
			violation_q <= ST_OK;
			active_q    <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= '0;
			rec_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			violation_q <= viol_d;
			active_q    <= active_d;
			done_q      <= emit;
			rec_q       <= emit && rec_d;
			if (emit) status_q <= viol_d;
			if (state_q == BK_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_ROW) init_q <= 1'b0;
			end else if (pop && head.act == ACT_START) begin
				clr_idx_q <= '0;
			end
		end
	end

	assign bk_status.init     = init_q;
	assign bk_status.clearing = (state_q == BK_CLEAR);
	assign done               = done_q;
	assign status             = status_q;
	assign reference_recorded = rec_q;

endmodule

>>> src/block_reference_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_reference_checker_top
// Filesystem double-allocation audit over a seen-bitmap of the data region.
// ----------------------------------------------------------------------------
// Results: an accepted request is queued, popped by the back end and its result registered onto
// done; a map reference also passes BK_CHECK (row read, then write). One request per cycle while busy is low.
// A start request sweeps the seen map, one 32-bit row a cycle: MAP_BITS/32 rows (1024).
// Reset: the same sweep runs after reset with busy held high until it ends.
// Results come on done for one cycle; the receiver cannot stall.
`include "block_reference_checker_top_macros.svh"

module block_reference_checker_top
	import brc_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            action,
	input  logic [3:0]            inode_type,
	input  logic signed [15:0]    link_count,
	input  logic [31:0]           block_number,
	input  logic                  marked_used,
	output logic                  done,
	output logic [2:0]            status,
	output logic                  reference_recorded
);

	localparam int MAP_IDX_W = $clog2(MAP_BITS);
	localparam int ENTRY_W   = $bits(cls_t) + MAP_IDX_W;

	cls_t                 f_cls, q_cls;
	logic [MAP_IDX_W-1:0] f_offset, q_offset;
	logic                 push, pop, q_valid, q_full, accept;
	bk_status_t           bk_status;

	assign accept = start && !busy;
	assign busy   = q_full || bk_status.init;

	brc_front #(
		.MAP_BITS(MAP_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.action      (action),
		.inode_type  (inode_type),
		.link_count  (link_count),
		.block_number(block_number),
		.marked_used (marked_used),
		.cls         (f_cls),
		.offset      (f_offset),
		.push        (push)
	);

	brc_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({f_cls, f_offset}),
		.pop   (pop),
		.rdata ({q_cls, q_offset}),
		.valid (q_valid),
		.full  (q_full)
	);

	brc_back #(
		.MAP_BITS(MAP_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.head              (q_cls),
		.head_offset       (q_offset),
		.pop               (pop),
		.bk_status         (bk_status),
		.done              (done),
		.status            (status),
		.reference_recorded(reference_recorded)
	);

	`BRC_ASSERT_IMPL(a_rec_ok, reference_recorded, done && (status == ST_OK || status == ST_FREE), "recorded reference with wrong status or no strobe")
	`BRC_ASSERT_IMPL(a_status_code, done, status <= ST_FREE, "status code out of range")
	`BRC_ASSERT_NEXT(a_no_result_in_sweep, bk_status.clearing, !done, "result strobe during map sweep")
	`BRC_ASSERT_IMPL(a_no_pop_empty, pop, q_valid, "pop from an empty queue")
	`BRC_ASSERT_NEXT(a_accept_queued, accept, q_valid, "accepted request not queued")

endmodule
